// ===== rtl/tsbd_pkg.sv =====
// Shared constants for the tour swap descent block: field widths and request codes.
// No dependencies; imported by the top module and the checker.
`timescale 1ns / 1ps
`default_nettype none
package tsbd_pkg;

  localparam int POS_W   = 6;   // tour positions and city numbers
  localparam int DIN_W   = 16;  // distance field of a load request
  localparam int COST_W  = 22;  // reported tour cost
  localparam int MOVE_W  = 16;  // reported move count
  localparam int CC_W    = 7;   // city count register

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [MOVE_W-1:0] MOVE_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_DIST = 2'd0,
    FUNC_TOUR = 2'd1,
    FUNC_RUN  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

endpackage
`default_nettype wire

// ===== rtl/tsbd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Used for the distance matrix and the tour; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module tsbd_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/tour_swap_best_improvement_descent_top.sv =====
// Tour swap descent: loads a distance matrix and a tour, runs best-improvement swap descent.
// Load requests are taken only while idle. A run first sums the initial closed tour cost,
// then per pass scans each of the n(n-1)/2 position pairs and applies the best improving
// swap; when no pair improves, it emits the tour one city at a time, held by output
// stalls. The pair scan is set by one tour read port and one distance read port feeding
// a single add/subtract accumulator.
// Reset clears control state and sets the city count to 64; both memories are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module tour_swap_best_improvement_descent_top
  import tsbd_pkg::*;
#(
  parameter int MAX_CITIES = 64,
  parameter int DIST_BITS  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CC_W-1:0]   cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        func_i,
  input  wire logic [POS_W-1:0]  from_city_i,
  input  wire logic [POS_W-1:0]  to_city_i,
  input  wire logic [DIN_W-1:0]  distance_i,
  input  wire logic [POS_W-1:0]  tour_position_i,
  input  wire logic [POS_W-1:0]  tour_city_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [POS_W-1:0]       position_o,
  output logic [POS_W-1:0]       city_o,
  output logic [COST_W-1:0]      tour_cost_o,
  output logic [MOVE_W-1:0]      moves_made_o,
  output logic                   last_o
);

  localparam int DD   = MAX_CITIES * MAX_CITIES;
  localparam int DAW  = $clog2(DD);
  localparam int TD   = (MAX_CITIES < 64) ? MAX_CITIES : 64;
  localparam int TAW  = $clog2(TD);
  localparam int CW   = DIST_BITS + 7;
  localparam int SW   = CW + 1;
  localparam int XW   = (CW > COST_W) ? CW : COST_W;
  localparam logic [CC_W-1:0] NLIM = CC_W'(TD);
  localparam logic [CC_W-1:0] NMIN = CC_W'(3);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_C0    = 4'd1;
  localparam logic [3:0] ST_C1    = 4'd2;
  localparam logic [3:0] ST_C2    = 4'd3;
  localparam logic [3:0] ST_C3    = 4'd4;
  localparam logic [3:0] ST_PINIT = 4'd5;
  localparam logic [3:0] ST_T     = 4'd6;
  localparam logic [3:0] ST_D     = 4'd7;
  localparam logic [3:0] ST_CMP   = 4'd8;
  localparam logic [3:0] ST_SW0   = 4'd9;
  localparam logic [3:0] ST_SW1   = 4'd10;
  localparam logic [3:0] ST_SW2   = 4'd11;
  localparam logic [3:0] ST_SW3   = 4'd12;
  localparam logic [3:0] ST_E0    = 4'd13;
  localparam logic [3:0] ST_E1    = 4'd14;
  localparam logic [3:0] ST_E2    = 4'd15;

  function automatic logic city_ok(input logic [POS_W-1:0] c);
    city_ok = (32'(c) < MAX_CITIES);
  endfunction

  function automatic logic [DAW-1:0] daddr(input logic [POS_W-1:0] a,
                                          input logic [POS_W-1:0] b);
    daddr = DAW'(32'(a) * MAX_CITIES + 32'(b));
  endfunction

  logic [3:0]        state_q, state_d;
  logic [CC_W-1:0]   cc_q, cc_d;
  logic [CC_W-1:0]   n_q, n_d;
  logic [POS_W-1:0]  k_q, k_d, i_q, i_d, j_q, j_d;
  logic [2:0]        s_q, s_d;
  logic [3:0]        d_q, d_d;
  logic [POS_W-1:0]  ca_q, ca_d, ta_q, ta_d;
  logic [POS_W-1:0]  slot_q [6];
  logic [POS_W-1:0]  slot_d [6];
  logic              use_q, use_d, sub_q, sub_d;
  logic [CW-1:0]     cost_q, cost_d, best_q, best_d;
  logic signed [SW-1:0] delta_q, delta_d;
  logic [POS_W-1:0]  bi_q, bi_d, bj_q, bj_d;
  logic              impr_q, impr_d;
  logic [MOVE_W-1:0] moves_q, moves_d;
  logic              ov_q, ov_d, last_q, last_d;
  logic [POS_W-1:0]  opos_q, opos_d, ocity_q, ocity_d;

  logic                 t_we, d_we;
  logic [TAW-1:0]       t_waddr, t_raddr;
  logic [POS_W-1:0]     t_wdata, t_rdata;
  logic [DAW-1:0]       d_waddr, d_raddr;
  logic [DIST_BITS-1:0] d_rdata;

  logic [POS_W-1:0]  nm1, nxk;
  logic [POS_W-1:0]  pos [6];
  logic [POS_W-1:0]  cand [4];
  logic [3:0]        dist_k;
  logic [1:0]        ek;
  logic [2:0]        sa, sb;
  logic [POS_W-1:0]  ea, eb;
  logic signed [SW-1:0] dv, trial;
  logic              better;
  logic [XW-1:0]     cost_x;

  tsbd_ram #(.W(DIST_BITS), .D(DD)) u_dist_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(DIST_BITS'(distance_i)),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  tsbd_ram #(.W(POS_W), .D(TD)) u_tour_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  // positions around the pair under test
  always_comb begin
    nm1     = POS_W'(n_q - CC_W'(1));
    nxk     = (k_q == nm1) ? '0 : k_q + POS_W'(1);
    pos[0]  = (i_q == '0) ? nm1 : i_q - POS_W'(1);
    pos[1]  = i_q;
    pos[2]  = i_q + POS_W'(1);
    pos[3]  = j_q - POS_W'(1);
    pos[4]  = j_q;
    pos[5]  = (j_q == nm1) ? '0 : j_q + POS_W'(1);
    cand[0] = pos[0];
    cand[1] = pos[1];
    cand[2] = pos[3];
    cand[3] = pos[4];
    dist_k[0] = 1'b1;
    dist_k[1] = cand[1] != cand[0];
    dist_k[2] = (cand[2] != cand[0]) && (cand[2] != cand[1]);
    dist_k[3] = (cand[3] != cand[0]) && (cand[3] != cand[1]) && (cand[3] != cand[2]);
  end

  // edge endpoints for the current distance read, swapped on odd items
  always_comb begin
    ek = d_q[2:1];
    case (ek)
      2'd0:    sa = 3'd0;
      2'd1:    sa = 3'd1;
      2'd2:    sa = 3'd3;
      default: sa = 3'd4;
    endcase
    sb = sa + 3'd1;
    ea = slot_q[sa];
    eb = slot_q[sb];
    if (d_q[0]) begin
      if (pos[sa] == i_q)      ea = slot_q[4];
      else if (pos[sa] == j_q) ea = slot_q[1];
      if (pos[sb] == i_q)      eb = slot_q[4];
      else if (pos[sb] == j_q) eb = slot_q[1];
    end
  end

  // shared accumulator and trial cost compare
  always_comb begin
    dv     = signed'(SW'(d_rdata));
    trial  = signed'(SW'(cost_q)) + delta_q;
    better = trial[CW-1:0] < best_q;
    cost_x = XW'(cost_q);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cc_d = cc_q; n_d = n_q; k_d = k_q; i_d = i_q; j_d = j_q;
    s_d = s_q; d_d = d_q; ca_d = ca_q; ta_d = ta_q;
    slot_d = slot_q;
    use_d = use_q; sub_d = sub_q;
    cost_d = cost_q; best_d = best_q; delta_d = delta_q;
    bi_d = bi_q; bj_d = bj_q; impr_d = impr_q; moves_d = moves_q;
    ov_d = ov_q; last_d = last_q; opos_d = opos_q; ocity_d = ocity_q;
    t_we = 1'b0; t_waddr = tour_position_i[TAW-1:0]; t_wdata = tour_city_i;
    t_raddr = '0;
    d_we = 1'b0; d_waddr = daddr(from_city_i, to_city_i); d_raddr = '0;

    if (cfg_valid_i) cc_d = cfg_data_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_e'(func_i))
            FUNC_DIST: d_we = city_ok(from_city_i) && city_ok(to_city_i);
            FUNC_TOUR: t_we = city_ok(tour_position_i);
            FUNC_RUN: begin
              if (cc_q < NMIN)      n_d = NMIN;
              else if (cc_q > NLIM) n_d = NLIM;
              else                  n_d = cc_q;
              k_d = '0; cost_d = '0; moves_d = '0;
              state_d = ST_C0;
            end
            default: ;
          endcase
        end
      end
      // initial closed tour length
      ST_C0: begin
        t_raddr = k_q[TAW-1:0];
        state_d = ST_C1;
      end
      ST_C1: begin
        ca_d = t_rdata;
        t_raddr = nxk[TAW-1:0];
        state_d = ST_C2;
      end
      ST_C2: begin
        d_raddr = daddr(ca_q, t_rdata);
        use_d = city_ok(ca_q) && city_ok(t_rdata);
        state_d = ST_C3;
      end
      ST_C3: begin
        if (use_q) cost_d = cost_q + CW'(d_rdata);
        k_d = nxk;
        state_d = (k_q == nm1) ? ST_PINIT : ST_C0;
      end
      ST_PINIT: begin
        best_d = cost_q; impr_d = 1'b0;
        i_d = '0; j_d = POS_W'(1); s_d = '0;
        state_d = ST_T;
      end
      // fetch the six cities around the pair
      ST_T: begin
        if (s_q < 3'd6) t_raddr = pos[s_q][TAW-1:0];
        if (s_q != 3'd0) slot_d[s_q - 3'd1] = t_rdata;
        s_d = s_q + 3'd1;
        if (s_q == 3'd6) begin
          d_d = '0; delta_d = '0;
          state_d = ST_D;
        end
      end
      // eight distance reads: edges before (subtract) and after (add) the swap
      ST_D: begin
        if (d_q < 4'd8) begin
          d_raddr = daddr(ea, eb);
          use_d = dist_k[ek] && city_ok(ea) && city_ok(eb);
          sub_d = !d_q[0];
        end
        if (d_q != 4'd0 && use_q) delta_d = sub_q ? delta_q - dv : delta_q + dv;
        d_d = d_q + 4'd1;
        if (d_q == 4'd8) state_d = ST_CMP;
      end
      ST_CMP: begin
        if (better) begin
          best_d = trial[CW-1:0]; bi_d = i_q; bj_d = j_q; impr_d = 1'b1;
        end
        s_d = '0;
        if (j_q != nm1) begin
          j_d = j_q + POS_W'(1);
          state_d = ST_T;
        end else if (i_q + POS_W'(2) != POS_W'(n_q)) begin
          i_d = i_q + POS_W'(1);
          j_d = i_q + POS_W'(2);
          state_d = ST_T;
        end else if (impr_q || better) begin
          state_d = ST_SW0;
        end else begin
          k_d = '0;
          state_d = ST_E0;
        end
      end
      // exchange the winning pair
      ST_SW0: begin
        t_raddr = bi_q[TAW-1:0];
        state_d = ST_SW1;
      end
      ST_SW1: begin
        ta_d = t_rdata;
        t_raddr = bj_q[TAW-1:0];
        state_d = ST_SW2;
      end
      ST_SW2: begin
        t_we = 1'b1; t_waddr = bi_q[TAW-1:0]; t_wdata = t_rdata;
        state_d = ST_SW3;
      end
      ST_SW3: begin
        t_we = 1'b1; t_waddr = bj_q[TAW-1:0]; t_wdata = ta_q;
        cost_d = best_q;
        if (moves_q != MOVE_MAX) moves_d = moves_q + MOVE_W'(1);
        state_d = ST_PINIT;
      end
      // emit the final tour
      ST_E0: begin
        t_raddr = k_q[TAW-1:0];
        state_d = ST_E1;
      end
      ST_E1: begin
        ocity_d = t_rdata; opos_d = k_q; last_d = (k_q == nm1); ov_d = 1'b1;
        state_d = ST_E2;
      end
      ST_E2: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          k_d = k_q + POS_W'(1);
          state_d = last_q ? ST_IDLE : ST_E0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cc_q    <= CC_W'(64);
      ov_q    <= 1'b0;
      cost_q  <= '0;
      best_q  <= '0;
      bi_q    <= '0;
      bj_q    <= '0;
      moves_q <= '0;
    end else begin
      state_q <= state_d;
      cc_q    <= cc_d;
      ov_q    <= ov_d;
      cost_q  <= cost_d;
      best_q  <= best_d;
      bi_q    <= bi_d;
      bj_q    <= bj_d;
      moves_q <= moves_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q <= n_d; k_q <= k_d; i_q <= i_d; j_q <= j_d;
    s_q <= s_d; d_q <= d_d; ca_q <= ca_d; ta_q <= ta_d;
    slot_q <= slot_d;
    use_q <= use_d; sub_q <= sub_d; delta_q <= delta_d; impr_q <= impr_d;
    last_q <= last_d; opos_q <= opos_d; ocity_q <= ocity_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = ov_q;
  assign position_o   = opos_q;
  assign city_o       = ocity_q;
  assign last_o       = last_q;
  assign moves_made_o = moves_q;
  assign tour_cost_o  = (cost_x > XW'(COST_MAX)) ? COST_MAX : cost_x[COST_W-1:0];

  // checks
  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("result pending while idle");
  a_best_le_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (best_q <= cost_q)) else $error("best above current cost");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_T) |-> (j_q > i_q)) else $error("pair out of order");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o) else $error("no return to idle");

endmodule
`default_nettype wire

// ===== test/tour_swap_descent_checker.sv =====
// Checker for the tour swap descent block: watches the configuration, request and result
// channels, predicts every emitted city and compares. Depends on tsbd_pkg.
`timescale 1ns / 1ps
module tour_swap_descent_checker
  import tsbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CC_W-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        func_i,
  input  logic [POS_W-1:0]  from_city_i,
  input  logic [POS_W-1:0]  to_city_i,
  input  logic [DIN_W-1:0]  distance_i,
  input  logic [POS_W-1:0]  tour_position_i,
  input  logic [POS_W-1:0]  tour_city_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [POS_W-1:0]  city_i,
  input  logic [COST_W-1:0] tour_cost_i,
  input  logic [MOVE_W-1:0] moves_made_i,
  input  logic              last_i,
  output int                mismatch_count,
  output int                pending_count
);

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  city;
    logic [COST_W-1:0] cost;
    logic [MOVE_W-1:0] moves;
    logic              last;
  } tour_city_t;

  tour_city_t       emitted_tour_q[$];
  logic [DIN_W-1:0] dist_mem [64][64];
  logic [POS_W-1:0] tour_mem [64];
  int unsigned      city_count_reg;

  // city at position p with positions si and sj exchanged
  function automatic int unsigned city_after_swap(int unsigned p, int unsigned si,
                                                  int unsigned sj);
    if (p == si) return tour_mem[sj];
    if (p == sj) return tour_mem[si];
    return tour_mem[p];
  endfunction

  function automatic longint edge_length(int unsigned k, int unsigned n, int unsigned si,
                                         int unsigned sj);
    int unsigned nx;
    nx = (k + 1 == n) ? 0 : k + 1;
    return dist_mem[city_after_swap(k, si, sj)][city_after_swap(nx, si, sj)];
  endfunction

  // cost of the tour with i and j exchanged, each touched edge counted once
  function automatic longint swapped_cost(longint cost, int unsigned n, int unsigned i,
                                          int unsigned j);
    int unsigned cand [4];
    int unsigned edges [4];
    int unsigned cnt;
    bit          dup;
    longint      was, now;
    cnt = 0;
    was = 0;
    now = 0;
    cand[0] = (i == 0) ? n - 1 : i - 1;
    cand[1] = i;
    cand[2] = (j == 0) ? n - 1 : j - 1;
    cand[3] = j;
    for (int k = 0; k < 4; k++) begin
      dup = 0;
      for (int m = 0; m < cnt; m++) if (edges[m] == cand[k]) dup = 1;
      if (!dup) begin
        edges[cnt] = cand[k];
        cnt++;
      end
    end
    for (int k = 0; k < cnt; k++) begin
      was += edge_length(edges[k], n, n, n);
      now += edge_length(edges[k], n, i, j);
    end
    return cost - was + now;
  endfunction

  // run the descent on the local copy and queue the emitted tour
  task automatic predict_descent();
    int unsigned      n, best_i, best_j, moves;
    longint           cost, best, c;
    bit               improved;
    logic [POS_W-1:0] t;
    tour_city_t       r;
    n = city_count_reg;
    if (n < 3) n = 3;
    if (n > 64) n = 64;
    cost = 0;
    for (int k = 0; k < n; k++) cost += edge_length(k, n, n, n);
    moves = 0;
    best_i = 0;
    best_j = 0;
    do begin
      improved = 0;
      best = cost;
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          c = swapped_cost(cost, n, i, j);
          if (c < best) begin
            best = c;
            best_i = i;
            best_j = j;
            improved = 1;
          end
        end
      end
      if (improved) begin
        t = tour_mem[best_i];
        tour_mem[best_i] = tour_mem[best_j];
        tour_mem[best_j] = t;
        cost = best;
        if (moves < 65535) moves++;
      end
    end while (improved);
    for (int k = 0; k < n; k++) begin
      r.position = POS_W'(k);
      r.city     = tour_mem[k];
      r.cost     = (cost > longint'(COST_MAX)) ? COST_MAX : cost[COST_W-1:0];
      r.moves    = MOVE_W'(moves);
      r.last     = (k + 1 == n);
      emitted_tour_q = {emitted_tour_q, r};
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tour_city_t want;
    if (!rst_ni) begin
      city_count_reg = 64;
      mismatch_count = 0;
      emitted_tour_q.delete();
    end else begin
      // track the register
      if (cfg_valid_i && cfg_ready_i) city_count_reg = 32'(cfg_data_i);
      // compare each emitted city with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (emitted_tour_q.size() == 0) begin
          report_mismatch("unexpected result, position", position_i, 0);
        end else begin
          want = emitted_tour_q.pop_front();
          if (position_i !== want.position) report_mismatch("position", position_i,
                                                            want.position);
          if (city_i !== want.city) report_mismatch("city", city_i, want.city);
          if (tour_cost_i !== want.cost) report_mismatch("tour_cost", tour_cost_i,
                                                         want.cost);
          if (moves_made_i !== want.moves) report_mismatch("moves_made", moves_made_i,
                                                           want.moves);
          if (last_i !== want.last) report_mismatch("last", last_i, want.last);
        end
      end
      // apply each accepted request to the local copy
      if (in_valid_i && in_ready_i) begin
        case (func_e'(func_i))
          FUNC_DIST: dist_mem[from_city_i][to_city_i] = distance_i;
          FUNC_TOUR: tour_mem[tour_position_i] = tour_city_i;
          FUNC_RUN:  predict_descent();
          default: ;
        endcase
      end
    end
    pending_count = emitted_tour_q.size();
  end

endmodule

// ===== test/tour_swap_best_improvement_descent_top_test.sv =====
// Testbench top for the tour swap descent block: drives load, run and idle requests and
// the city count register under several idling phases. Depends on tsbd_pkg and the checker.
`timescale 1ns / 1ps
module tour_swap_best_improvement_descent_top_test;
  import tsbd_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CC_W-1:0]   cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        func_i;
  logic [POS_W-1:0]  from_city_i;
  logic [POS_W-1:0]  to_city_i;
  logic [DIN_W-1:0]  distance_i;
  logic [POS_W-1:0]  tour_position_i;
  logic [POS_W-1:0]  tour_city_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [POS_W-1:0]  position_o;
  logic [POS_W-1:0]  city_o;
  logic [COST_W-1:0] tour_cost_o;
  logic [MOVE_W-1:0] moves_made_o;
  logic              last_o;

  int mismatch_count;
  int pending_count;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_request;
  bit  hold_done;
  int  requests_sent;
  logic [POS_W-1:0] city_set [8];

  tour_swap_best_improvement_descent_top uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .func_i, .from_city_i, .to_city_i, .distance_i, .tour_position_i, .tour_city_i,
    .out_valid_o, .out_ready_i,
    .position_o, .city_o, .tour_cost_o, .moves_made_o, .last_o
  );

  tour_swap_descent_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .func_i, .from_city_i, .to_city_i, .distance_i, .tour_position_i, .tour_city_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .position_i(position_o), .city_i(city_o), .tour_cost_i(tour_cost_o),
    .moves_made_i(moves_made_o), .last_i(last_o),
    .mismatch_count, .pending_count
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #120ms;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random stalls, plus one long hold-off once results appear when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request && out_valid_o) begin
        hold_left = 400;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // offer one request, with an optional idle gap first; returns at its accepting edge
  task automatic send_request(func_e f, logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                              logic [DIN_W-1:0] d, logic [POS_W-1:0] p,
                              logic [POS_W-1:0] c);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1;
    func_i          <= f;
    from_city_i     <= a;
    to_city_i       <= b;
    distance_i      <= d;
    tour_position_i <= p;
    tour_city_i     <= c;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  task automatic load_distance(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                               logic [DIN_W-1:0] d);
    send_request(FUNC_DIST, a, b, d, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic load_tour(logic [POS_W-1:0] p, logic [POS_W-1:0] c);
    send_request(FUNC_TOUR, POS_W'($urandom), POS_W'($urandom), DIN_W'($urandom), p, c);
  endtask

  task automatic start_run();
    send_request(FUNC_RUN, POS_W'($urandom), POS_W'($urandom), DIN_W'($urandom),
                 POS_W'($urandom), POS_W'($urandom));
  endtask

  // wait for the block to drain, then write the city count
  task automatic set_city_count(logic [CC_W-1:0] value);
    in_valid_i <= 0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [DIN_W-1:0] pick_distance();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 16'd7;
      default: return DIN_W'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    rst_ni          = 0;
    cfg_valid_i     = 0;
    cfg_data_i      = 0;
    in_valid_i      = 0;
    func_i          = FUNC_DIST;
    from_city_i     = 0;
    to_city_i       = 0;
    distance_i      = 0;
    tour_position_i = 0;
    tour_city_i     = 0;
    hold_request    = 0;
    hold_done       = 0;
    requests_sent   = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // working set of cities: the two extremes and six random ones
    city_set[0] = POS_W'(0);
    city_set[1] = POS_W'(63);
    for (int k = 2; k < 8; k++) city_set[k] = POS_W'($urandom);

    // fill every used distance and every tour position; a self distance of zero
    // on the first city makes an all-same tour cost nothing
    for (int a = 0; a < 8; a++)
      for (int b = 0; b < 8; b++)
        load_distance(city_set[a], city_set[b],
                      (city_set[a] == 0 && city_set[b] == 0) ? '0 : pick_distance());
    for (int p = 0; p < 64; p++) load_tour(POS_W'(p), POS_W'(0));

    // full tour at reset value, then above and below the legal range
    start_run();
    set_city_count(CC_W'(127));
    start_run();
    set_city_count(CC_W'(0));
    start_run();
    set_city_count(CC_W'(1));
    load_tour(POS_W'(1), POS_W'(63));
    load_tour(POS_W'(2), city_set[3]);
    send_request(FUNC_NONE, '1, '1, '1, '1, '1);
    start_run();
    set_city_count(CC_W'(2));
    start_run();
    set_city_count(CC_W'(3));
    start_run();

    // random part in four idling phases
    requests_sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 32 : 71) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 32 : 71) : 0;
      while (requests_sent < (phase + 1) * 33) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
        set_city_count(CC_W'(n));
        if (n < 3) n = 3;
        // reshuffle the tour with cities from the working set
        for (int p = 0; p < n; p++)
          if ($urandom_range(0, 2) != 0)
            load_tour(POS_W'(p), city_set[$urandom_range(0, 7)]);
        // rewrite some distances and add some ignored noise
        repeat ($urandom_range(0, 6))
          load_distance(city_set[$urandom_range(0, 7)], city_set[$urandom_range(0, 7)],
                        pick_distance());
        if ($urandom_range(0, 3) == 0)
          send_request(FUNC_NONE, POS_W'($urandom), POS_W'($urandom), DIN_W'($urandom),
                       POS_W'($urandom), POS_W'($urandom));
        start_run();
        // hold the result side off while more requests queue behind the run
        if (phase == 0 && !hold_done && requests_sent > 10) begin
          hold_done = 1;
          hold_request = 1;
          load_tour(POS_W'(0), city_set[$urandom_range(0, 7)]);
          load_distance(city_set[2], city_set[5], pick_distance());
          start_run();
        end
      end
    end

    in_valid_i <= 0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
